### src/grc_pkg.sv
// shared types, constants and wall map for the grid raycaster column block
package grc_pkg;

  localparam int MAP_SIZE_DEF      = 16;
  localparam int MAX_DDA_STEPS_DEF = 64;
  localparam int MAX_HEIGHT_DEF    = 64;

  localparam int ROM_DIM  = 16;
  localparam int ONE_Q14  = 16384;
  localparam int DIST_MIN = 1638;
  localparam int DIST_FAR = 73728;

  // register indexes of the configuration port
  localparam logic [7:0] REG_SCREEN_WIDTH  = 8'd0;
  localparam logic [7:0] REG_SCREEN_HEIGHT = 8'd1;

  typedef struct packed {
    logic [6:0]         column;
    logic [15:0]        pos_x;
    logic [15:0]        pos_y;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] plane_x;
    logic signed [15:0] plane_y;
  } grc_req_t;

  typedef struct packed {
    logic [63:0] column_bits;
    logic        wall_side;
    logic [15:0] wall_distance;
    logic [6:0]  wall_height;
  } grc_res_t;

  // wall map rows, bit i is map column i
  localparam logic [15:0] WALL_ROWS [ROM_DIM] = '{
    16'hFFFF, 16'h8001, 16'hB7BD, 16'hA425, 16'hA5E5, 16'h8421, 16'hBDBD, 16'h8181,
    16'hBDBD, 16'h8421, 16'hA5E5, 16'hA425, 16'hB7BD, 16'h8001, 16'h8001, 16'hFFFF
  };

  function automatic logic rom_wall(input logic [3:0] cx, input logic [3:0] cy);
    logic [15:0] row;
    row = WALL_ROWS[cy];
    return row[cx];
  endfunction

endpackage

### src/grid_raycast_column.sv
// grid raycaster column: ray setup, dda walk and column mask generation
// One request at a time runs through a small sequencer around one shared
// restoring divider (used four times: camera x, both ray deltas and the
// wall height) and one shared multiplier (four uses). The DDA walk runs up
// to MAX_DDA_STEPS steps. The next request can be taken once the result is
// loaded into the output register. cmd_stall is high while a request is in
// flight; a finished result waits in the output register and a new request
// may be taken meanwhile. Configuration writes are always ready.
module grid_raycast_column #(
  parameter int MAP_SIZE      = grc_pkg::MAP_SIZE_DEF,
  parameter int MAX_DDA_STEPS = grc_pkg::MAX_DDA_STEPS_DEF,
  parameter int MAX_HEIGHT    = grc_pkg::MAX_HEIGHT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  grc_pkg::grc_req_t cmd,
  output logic              res_valid,
  input  logic              res_stall,
  output grc_pkg::grc_res_t res,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [7:0]        cfg_index,
  input  logic [7:0]        cfg_data
);
  import grc_pkg::*;

  localparam int NW   = 29;                                // divider dividend width
  localparam int DW   = 41;                                // delta width, holds 2^40
  localparam int SDW  = DW + $clog2(MAX_DDA_STEPS + 1) + 1; // side distance width
  localparam int CW   = $clog2(MAP_SIZE + MAX_DDA_STEPS) + 2;
  localparam int RW   = 26;                                // ray component width
  localparam int CAMW = 24;
  localparam int SCW  = $clog2(MAX_DDA_STEPS);
  localparam logic [SDW-1:0] DELTA_INF = SDW'(64'd1 << 40);

  typedef enum logic [3:0] {
    S_IDLE, S_CAM_DIV, S_RAY_X, S_RAY_Y, S_DELX_DIV, S_DELY_DIV,
    S_SIDE_X, S_SIDE_Y, S_WALK, S_HEIGHT_DIV, S_DONE
  } state_t;

  state_t state;
  grc_req_t item;
  logic [7:0] screen_width;
  logic [6:0] screen_height;

  logic signed [CAMW-1:0] cam;
  logic signed [RW-1:0]   rx, ry;
  logic [SDW-1:0] delx, dely, sdx, sdy, wall_dist;
  logic signed [CW-1:0] mx, my;
  logic side;
  logic [SCW-1:0] step_cnt;
  logic [6:0] lh;

  // shared divider
  logic [NW-1:0]  div_num, div_quo;
  logic [SDW-1:0] div_den, div_rem;
  logic [4:0]     div_cnt;
  logic [SDW:0]   div_trial;
  logic           div_ge;
  logic [SDW-1:0] div_rem_next;
  logic [NW-1:0]  div_quo_next;
  logic           div_last;

  assign div_trial    = {div_rem, div_num[NW-1]};
  assign div_ge       = div_trial >= {1'b0, div_den};
  assign div_rem_next = div_ge ? SDW'(div_trial - {1'b0, div_den}) : div_trial[SDW-1:0];
  assign div_quo_next = {div_quo[NW-2:0], div_ge};
  assign div_last     = div_cnt == 5'(NW - 1);

  // shared multiplier, finite deltas fit in 29 bits
  logic signed [16:0] mul_a;
  logic signed [29:0] mul_b;
  logic signed [46:0] mul_p, mul_sh14;
  logic [46:0]        mul_sh12;
  logic [12:0]        frac_x, frac_y;

  assign frac_x = rx[RW-1] ? {1'b0, item.pos_x[11:0]} : 13'd4096 - {1'b0, item.pos_x[11:0]};
  assign frac_y = ry[RW-1] ? {1'b0, item.pos_y[11:0]} : 13'd4096 - {1'b0, item.pos_y[11:0]};

  always_comb begin
    unique case (state)
      S_RAY_X: begin
        mul_a = 17'(item.plane_x);
        mul_b = 30'(cam);
      end
      S_RAY_Y: begin
        mul_a = 17'(item.plane_y);
        mul_b = 30'(cam);
      end
      S_SIDE_X: begin
        mul_a = $signed({4'd0, frac_x});
        mul_b = $signed({1'b0, delx[28:0]});
      end
      S_SIDE_Y: begin
        mul_a = $signed({4'd0, frac_y});
        mul_b = $signed({1'b0, dely[28:0]});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p    = mul_a * mul_b;
  assign mul_sh14 = mul_p >>> 14;
  assign mul_sh12 = 47'(mul_p) >> 12;

  // ray component from direction plus scaled plane
  logic signed [RW-1:0] ray_c;
  always_comb begin
    if (state == S_RAY_X) begin
      ray_c = RW'(item.dir_x) + $signed(mul_sh14[RW-1:0]);
    end else begin
      ray_c = RW'(item.dir_y) + $signed(mul_sh14[RW-1:0]);
    end
  end

  logic [RW-1:0] abs_rx, abs_ry;
  assign abs_rx = rx[RW-1] ? RW'(-rx) : RW'(rx);
  assign abs_ry = ry[RW-1] ? RW'(-ry) : RW'(ry);

  // one dda step
  logic step_x;
  logic signed [CW-1:0] mx_n, my_n;
  logic [SDW-1:0] sdx_n, sdy_n, dist_raw, dist_c;
  logic side_n, hit;

  always_comb begin
    step_x = sdx < sdy;
    mx_n = mx;
    my_n = my;
    sdx_n = sdx;
    sdy_n = sdy;
    if (step_x) begin
      sdx_n = sdx + delx;
      mx_n = rx[RW-1] ? mx - CW'(1) : mx + CW'(1);
    end else begin
      sdy_n = sdy + dely;
      my_n = ry[RW-1] ? my - CW'(1) : my + CW'(1);
    end
    side_n = !step_x;
    if (mx_n < 0 || my_n < 0 || mx_n >= CW'(MAP_SIZE) || my_n >= CW'(MAP_SIZE) ||
        mx_n >= CW'(ROM_DIM) || my_n >= CW'(ROM_DIM)) begin
      hit = 1'b1;
    end else begin
      hit = rom_wall(mx_n[3:0], my_n[3:0]);
    end
    dist_raw = side_n ? sdy_n - dely : sdx_n - delx;
    dist_c = (dist_raw < SDW'(DIST_MIN)) ? SDW'(DIST_MIN) : dist_raw;
  end

  // effective register values
  logic [7:0] w_eff;
  logic [6:0] h_eff;
  assign w_eff = (screen_width == 8'd0) ? 8'd1 : screen_width;
  assign h_eff = (screen_height > 7'(MAX_HEIGHT)) ? 7'(MAX_HEIGHT) : screen_height;

  // column mask from the slice height
  logic [6:0] top, bot, bot_raw;
  logic far_hit;
  logic [63:0] mask;
  logic [15:0] q88;

  always_comb begin
    logic [7:0] xy;
    top = (h_eff >> 1) - (lh >> 1);
    bot_raw = (h_eff >> 1) + (lh >> 1);
    bot = (bot_raw >= h_eff) ? h_eff - 7'd1 : bot_raw;
    far_hit = wall_dist > SDW'(DIST_FAR);
    mask = '0;
    for (int y = 0; y < 64; y++) begin
      xy = 8'(item.column) + 8'(y);
      if (h_eff != 7'd0 && 7'(y) >= top && 7'(y) <= bot) begin
        mask[y] = (side || !xy[0]) && (!far_hit || xy[1:0] == 2'd0);
      end
    end
    if (lh > 7'd2) begin
      mask[top[5:0]] = 1'b1;
      mask[bot[5:0]] = 1'b1;
    end
    q88 = ((wall_dist >> 6) > SDW'(65535)) ? 16'hFFFF : wall_dist[21:6];
  end

  assign cmd_stall = state != S_IDLE;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width <= 8'd128;
      screen_height <= 7'd64;
    end else if (cfg_valid) begin
      if (cfg_index == REG_SCREEN_WIDTH) begin
        screen_width <= cfg_data;
      end else if (cfg_index == REG_SCREEN_HEIGHT) begin
        screen_height <= cfg_data[6:0];
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      // output register handshake
      if (state == S_DONE && (!res_valid || !res_stall)) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      // divider iteration, the last one is taken from the next-value logic
      if ((state == S_CAM_DIV || state == S_DELX_DIV || state == S_DELY_DIV ||
           state == S_HEIGHT_DIV) && !div_last) begin
        div_num <= {div_num[NW-2:0], 1'b0};
        div_rem <= div_rem_next;
        div_quo <= div_quo_next;
        div_cnt <= div_cnt + 5'd1;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            item <= cmd;
            div_num <= NW'({cmd.column, 15'd0});
            div_den <= SDW'(w_eff);
            div_rem <= '0;
            div_cnt <= '0;
            state <= S_CAM_DIV;
          end
        end
        S_CAM_DIV: begin
          if (div_last) begin
            cam <= $signed(CAMW'(div_quo_next)) - CAMW'(ONE_Q14);
            state <= S_RAY_X;
          end
        end
        S_RAY_X: begin
          rx <= ray_c;
          state <= S_RAY_Y;
        end
        S_RAY_Y: begin
          ry <= ray_c;
          div_num <= NW'(1) << 28;
          div_den <= SDW'(abs_rx);
          div_rem <= '0;
          div_cnt <= '0;
          state <= S_DELX_DIV;
        end
        S_DELX_DIV: begin
          if (div_last) begin
            delx <= (rx == 0) ? DELTA_INF : SDW'(div_quo_next);
            div_num <= NW'(1) << 28;
            div_den <= SDW'(abs_ry);
            div_rem <= '0;
            div_cnt <= '0;
            state <= S_DELY_DIV;
          end
        end
        S_DELY_DIV: begin
          if (div_last) begin
            dely <= (ry == 0) ? DELTA_INF : SDW'(div_quo_next);
            state <= S_SIDE_X;
          end
        end
        // an infinite delta scales the fraction by a plain shift
        S_SIDE_X: begin
          sdx <= (rx == 0) ? SDW'({frac_x, 28'd0}) : SDW'(mul_sh12);
          state <= S_SIDE_Y;
        end
        S_SIDE_Y: begin
          sdy <= (ry == 0) ? SDW'({frac_y, 28'd0}) : SDW'(mul_sh12);
          mx <= CW'(item.pos_x[15:12]);
          my <= CW'(item.pos_y[15:12]);
          step_cnt <= '0;
          state <= S_WALK;
        end
        S_WALK: begin
          sdx <= sdx_n;
          sdy <= sdy_n;
          mx <= mx_n;
          my <= my_n;
          side <= side_n;
          step_cnt <= step_cnt + SCW'(1);
          if (hit || step_cnt == SCW'(MAX_DDA_STEPS - 1)) begin
            wall_dist <= dist_c;
            div_num <= NW'({h_eff, 14'd0});
            div_den <= dist_c;
            div_rem <= '0;
            div_cnt <= '0;
            state <= S_HEIGHT_DIV;
          end
        end
        S_HEIGHT_DIV: begin
          if (div_last) begin
            lh <= (div_quo_next > NW'(h_eff)) ? h_eff : div_quo_next[6:0];
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!res_valid || !res_stall) begin
            res.column_bits <= mask;
            res.wall_side <= side;
            res.wall_distance <= q88;
            res.wall_height <= lh;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  a_busy_stalls: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> cmd_stall) else $error("request taken while busy");
  a_height_bound: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.wall_height <= 7'(MAX_HEIGHT))) else $error("wall height too large");
  a_dist_floor: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.wall_distance >= 16'(DIST_MIN >> 6))) else $error("distance below floor");
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (32'(step_cnt) < MAX_DDA_STEPS)) else $error("walk overran");

endmodule

### verif/grid_raycast_column_tb.sv
// self-checking testbench for the grid raycaster column block
module grid_raycast_column_tb;
  import grc_pkg::*;

  logic        clk;
  logic        rst;
  logic        cmd_valid = 1'b0;
  logic        cmd_stall;
  grc_req_t    cmd = '0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  grc_res_t    res;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_index;
  logic [7:0]  cfg_data;

  grc_req_t    pending_reqs [$];
  grc_res_t    expected_cols [$];
  logic [7:0]  width_shadow;
  logic [6:0]  height_shadow;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          errors = 0;

  grid_raycast_column dut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
    .res_valid(res_valid), .res_stall(res_stall), .res(res),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic bit map_blocked(input longint cx, input longint cy);
    logic [15:0] row;
    if (cx < 0 || cy < 0 || cx >= 16 || cy >= 16) return 1'b1;
    row = WALL_ROWS[cy];
    return row[cx];
  endfunction

  // column render from the camera snapshot and the current screen size
  function automatic grc_res_t render_column(input grc_req_t q);
    grc_res_t r;
    longint x, px, py, dx, dy, plx, ply, w, h, cam, rx, ry, mx, my, fx, fy;
    longint delx, dely, stx, sty, sdx, sdy, wall_dist, lh, top, bot, q88;
    int side;
    logic [63:0] mask;
    bit far, on;
    x = q.column;
    px = q.pos_x;
    py = q.pos_y;
    dx = q.dir_x;
    dy = q.dir_y;
    plx = q.plane_x;
    ply = q.plane_y;
    w = (width_shadow == 0) ? 1 : width_shadow;
    h = (height_shadow > 64) ? 64 : height_shadow;
    cam = (2 * x * 16384) / w - 16384;
    rx = dx + ((plx * cam) >>> 14);
    ry = dy + ((ply * cam) >>> 14);
    mx = px >> 12;
    my = py >> 12;
    fx = px & 'hFFF;
    fy = py & 'hFFF;
    delx = (rx == 0) ? (64'sd1 << 40) : ((64'sd1 << 28) / (rx < 0 ? -rx : rx));
    dely = (ry == 0) ? (64'sd1 << 40) : ((64'sd1 << 28) / (ry < 0 ? -ry : ry));
    if (rx < 0) begin
      stx = -1;
      sdx = (fx * delx) >> 12;
    end else begin
      stx = 1;
      sdx = ((4096 - fx) * delx) >> 12;
    end
    if (ry < 0) begin
      sty = -1;
      sdy = (fy * dely) >> 12;
    end else begin
      sty = 1;
      sdy = ((4096 - fy) * dely) >> 12;
    end
    // dda walk
    side = 0;
    for (int n = 0; n < 64; n++) begin
      if (sdx < sdy) begin
        sdx += delx;
        mx += stx;
        side = 0;
      end else begin
        sdy += dely;
        my += sty;
        side = 1;
      end
      if (map_blocked(mx, my)) break;
    end
    wall_dist = (side == 0) ? (sdx - delx) : (sdy - dely);
    if (wall_dist < 1638) wall_dist = 1638;
    lh = (h * 16384) / wall_dist;
    if (lh > h) lh = h;
    top = h / 2 - lh / 2;
    bot = h / 2 + lh / 2;
    if (top < 0) top = 0;
    if (bot >= h) bot = h - 1;
    // pixel mask with dithering and edge pixels
    mask = '0;
    far = wall_dist > 73728;
    for (longint y = top; y <= bot; y++) begin
      on = (side == 1) ? 1'b1 : (((x + y) & 1) == 0);
      if (far) on = on && (((x + y) & 3) == 0);
      if (on && y < 64) mask[y] = 1'b1;
    end
    if (lh > 2) begin
      if (top >= 0 && top < 64) mask[top] = 1'b1;
      if (bot >= 0 && bot < 64) mask[bot] = 1'b1;
    end
    q88 = wall_dist >> 6;
    if (q88 > 65535) q88 = 65535;
    r.column_bits = mask;
    r.wall_side = side[0];
    r.wall_distance = q88[15:0];
    r.wall_height = lh[6:0];
    return r;
  endfunction

  // request driver
  always @(posedge clk) begin
    bit accepted;
    bit show;
    grc_req_t nxt;
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      accepted = cmd_valid && !cmd_stall;
      if (accepted) expected_cols.push_back(render_column(cmd));
      if (!cmd_valid || accepted) begin
        show = pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct;
        if (show) begin
          nxt = pending_reqs.pop_front();
          cmd <= nxt;
        end
        cmd_valid <= show;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    grc_res_t want;
    if (!rst && res_valid && !res_stall) begin
      if (expected_cols.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", res);
      end else begin
        want = expected_cols.pop_front();
        if (want.column_bits !== res.column_bits || want.wall_side !== res.wall_side ||
            want.wall_distance !== res.wall_distance ||
            want.wall_height !== res.wall_height) begin
          errors++;
          if (errors <= 10)
            $display({"mismatch: exp bits %h side %0d dist %0d h %0d, ",
                      "got bits %h side %0d dist %0d h %0d"},
                     want.column_bits, want.wall_side, want.wall_distance, want.wall_height,
                     res.column_bits, res.wall_side, res.wall_distance, res.wall_height);
        end
      end
    end
    res_stall <= rst ? 1'b0 : ($urandom_range(99) < recv_stall_pct);
  end

  task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_SCREEN_WIDTH) width_shadow = val;
    else if (idx == REG_SCREEN_HEIGHT) height_shadow = val[6:0];
    cfg_valid <= 1'b0;
  endtask

  task automatic add_req(input int c, input int px, input int py,
                         input int dx, input int dy,
                         input int plx, input int ply);
    grc_req_t q;
    q.column = 7'(c);
    q.pos_x = 16'(px);
    q.pos_y = 16'(py);
    q.dir_x = 16'(dx);
    q.dir_y = 16'(dy);
    q.plane_x = 16'(plx);
    q.plane_y = 16'(ply);
    pending_reqs.push_back(q);
  endtask

  // camera in an open cell looking somewhere, or plain noise
  task automatic add_random_req();
    int cx, cy, dx, dy;
    if ($urandom_range(99) < 80) begin
      do begin
        cx = $urandom_range(15);
        cy = $urandom_range(15);
      end while (map_blocked(cx, cy));
      dx = $urandom_range(32768) - 16384;
      dy = $urandom_range(32768) - 16384;
      add_req($urandom_range(127), (cx << 12) | $urandom_range(4095),
              (cy << 12) | $urandom_range(4095), dx, dy, -dy * 2 / 3, dx * 2 / 3);
    end else begin
      add_req($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_reqs.size() > 0 || cmd_valid || expected_cols.size() > 0);
  endtask

  initial begin
    int widths [8];
    int heights [8];
    widths = '{128, 1, 255, 0, 37, 128, 64, 200};
    heights = '{64, 1, 127, 0, 20, 63, 2, 64};
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    width_shadow = 8'd128;
    height_shadow = 7'd64;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes, axis rays, zero ray, corners and walls
    add_req(0, 16'h1800, 16'h1800, 16384, 0, 0, 10813);
    add_req(127, 16'h1800, 16'h1800, 16384, 0, 0, 10813);
    add_req(64, 16'h1800, 16'h1800, 16384, 0, 0, 0);
    add_req(64, 16'h1800, 16'h1800, 0, 16384, 0, 0);
    add_req(64, 16'h1800, 16'h1800, 0, 0, 0, 0);
    add_req(0, 16'h0000, 16'h0000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    add_req(127, 16'hFFFF, 16'hFFFF, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    add_req(127, 16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
    add_req(10, 16'h7800, 16'h7800, -16384, 0, 0, -10813);
    add_req(100, 16'hE800, 16'hD800, 0, -16384, 10813, 0);
    add_req(5, 16'h1001, 16'h1FFF, 16384, 16384, -10000, 10000);
    add_req(77, 16'h1800, 16'hE800, 16384, 0, 0, 10813);
    add_req(33, 16'h1800, 16'h1800, 16384, 1, 0, 0);
    add_req(90, 16'h1C00, 16'h1400, 16384, 0, 0, 0);
    add_req(127, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h1234, 16'hEDCB);

    for (int p = 0; p < 8; p++) begin
      if (p > 0) begin
        write_reg(REG_SCREEN_WIDTH, 8'(widths[p]));
        write_reg(REG_SCREEN_HEIGHT, 8'(heights[p]));
        // out-of-range index must be ignored
        if (p == 3) write_reg(8'd2, 8'hFF);
      end
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      repeat (92) add_random_req();
      wait_idle();
    end

    repeat (300) @(posedge clk);
    if (errors == 0 && expected_cols.size() == 0)
      $display("grid_raycast_column_tb: done, clean");
    else
      $display("grid_raycast_column_tb: done, errors");
    $finish;
  end

  // run limit
  initial begin
    #20000000;
    $display("grid_raycast_column_tb: done, errors");
    $finish;
  end

endmodule

### sim.f
src/grc_pkg.sv
src/grid_raycast_column.sv
verif/grid_raycast_column_tb.sv
